/* rtl/tcce_pkg.sv */
// Package for the text console character engine: geometry, character codes,
// sequencer control word, step codes and the microcode table.
// No dependencies.
package tcce_pkg;

    // Screen geometry (COLS must be a power of two)
    localparam int COLS    = 64;
    localparam int ROWS    = 32;
    localparam int COL_W   = $clog2(COLS);
    localparam int ROW_W   = $clog2(ROWS);
    localparam int CELL_AW = ROW_W + COL_W;
    localparam int CELLS   = COLS * ROWS;

    // Word field widths
    localparam int CH_W      = 8;
    localparam int IDX_W     = 11;
    localparam int OROW_W    = 5;
    localparam int OCOL_W    = 6;
    localparam int DATA_W    = 32;
    localparam int CFG_IDX_W = 1;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_ATTRIBUTE   = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CURSOR_BASE = 1'd1;

    // Commands
    localparam logic CMD_PUT  = 1'b0;
    localparam logic CMD_READ = 1'b1;

    // Character codes
    localparam logic [CH_W-1:0] CH_CR    = 8'h0D;
    localparam logic [CH_W-1:0] CH_LF    = 8'h0A;
    localparam logic [CH_W-1:0] CH_TAB   = 8'h09;
    localparam logic [CH_W-1:0] CH_RIGHT = 8'h91;
    localparam logic [CH_W-1:0] CH_UP    = 8'h90;
    localparam logic [CH_W-1:0] CH_LEFT  = 8'h93;
    localparam logic [CH_W-1:0] CH_DOWN  = 8'h92;
    localparam logic [CH_W-1:0] CH_HOME  = 8'h94;
    localparam logic [CH_W-1:0] CH_DEL   = 8'h99;
    localparam logic [CH_W-1:0] CH_BS    = 8'h08;
    localparam logic [CH_W-1:0] CH_CLR   = 8'h0C;
    localparam logic [CH_W-1:0] CH_BLANK = 8'h20;

    localparam int TAB_CNT_W = 3;
    localparam logic [TAB_CNT_W-1:0] TAB_SPACES = 3'd4;

    // Write data select
    localparam logic [1:0] WD_ZERO  = 2'd0;
    localparam logic [1:0] WD_CHAR  = 2'd1;
    localparam logic [1:0] WD_BLANK = 2'd2;
    localparam logic [1:0] WD_RDATA = 2'd3;

    // Pointer ops
    localparam logic [1:0] PTR_HOLD = 2'd0;
    localparam logic [1:0] PTR_INC  = 2'd1;
    localparam logic [1:0] PTR_ZERO = 2'd2;
    localparam logic [1:0] PTR_CUR  = 2'd3;

    // Cursor ops
    localparam logic [3:0] CUR_HOLD  = 4'd0;
    localparam logic [3:0] CUR_ADV   = 4'd1;
    localparam logic [3:0] CUR_CR    = 4'd2;
    localparam logic [3:0] CUR_LF    = 4'd3;
    localparam logic [3:0] CUR_RIGHT = 4'd4;
    localparam logic [3:0] CUR_LEFT  = 4'd5;
    localparam logic [3:0] CUR_UP    = 4'd6;
    localparam logic [3:0] CUR_DOWN  = 4'd7;
    localparam logic [3:0] CUR_HOME  = 4'd8;
    localparam logic [3:0] CUR_BACK  = 4'd9;
    localparam logic [3:0] CUR_ZERO  = 4'd10;

    // Jump conditions
    localparam logic [3:0] COND_NONE       = 4'd0;
    localparam logic [3:0] COND_ALWAYS     = 4'd1;
    localparam logic [3:0] COND_WRAP_LAST  = 4'd2;
    localparam logic [3:0] COND_ROW_LAST   = 4'd3;
    localparam logic [3:0] COND_TAB_MORE   = 4'd4;
    localparam logic [3:0] COND_PTR_SCR    = 4'd5;
    localparam logic [3:0] COND_PTR_TOP    = 4'd6;
    localparam logic [3:0] COND_COL_NZ     = 4'd7;
    localparam logic [3:0] COND_PTR_ROWEND = 4'd8;

    // Step codes
    localparam int UPC_W = 5;
    localparam logic [UPC_W-1:0] U_IDLE  = 5'd0;
    localparam logic [UPC_W-1:0] U_INIT  = 5'd1;
    localparam logic [UPC_W-1:0] U_READ  = 5'd2;
    localparam logic [UPC_W-1:0] U_PUT   = 5'd3;
    localparam logic [UPC_W-1:0] U_TAB   = 5'd4;
    localparam logic [UPC_W-1:0] U_TCHK  = 5'd5;
    localparam logic [UPC_W-1:0] U_CR    = 5'd6;
    localparam logic [UPC_W-1:0] U_LF    = 5'd7;
    localparam logic [UPC_W-1:0] U_RIGHT = 5'd8;
    localparam logic [UPC_W-1:0] U_LEFT  = 5'd9;
    localparam logic [UPC_W-1:0] U_UP    = 5'd10;
    localparam logic [UPC_W-1:0] U_DOWN  = 5'd11;
    localparam logic [UPC_W-1:0] U_HOME  = 5'd12;
    localparam logic [UPC_W-1:0] U_CLR0  = 5'd13;
    localparam logic [UPC_W-1:0] U_CLR1  = 5'd14;
    localparam logic [UPC_W-1:0] U_BS0   = 5'd15;
    localparam logic [UPC_W-1:0] U_BS1   = 5'd16;
    localparam logic [UPC_W-1:0] U_DEL0  = 5'd17;
    localparam logic [UPC_W-1:0] U_DEL1  = 5'd18;
    localparam logic [UPC_W-1:0] U_DEL2  = 5'd19;
    localparam logic [UPC_W-1:0] U_DEL3  = 5'd20;
    localparam logic [UPC_W-1:0] U_SCR0  = 5'd21;
    localparam logic [UPC_W-1:0] U_SCR1  = 5'd22;
    localparam logic [UPC_W-1:0] U_SCR2  = 5'd23;
    localparam logic [UPC_W-1:0] U_SCR3  = 5'd24;
    localparam logic [UPC_W-1:0] U_SCR4  = 5'd25;

    typedef struct packed {
        logic             rd;       // memory read
        logic             ra_cols;  // read at ptr+COLS, else ptr+1
        logic             wr;       // memory write
        logic             wa_cur;   // write at cursor cell, else at ptr
        logic [1:0]       wd_sel;
        logic [1:0]       ptr_op;
        logic [3:0]       cur_op;
        logic             tab_dec;
        logic [3:0]       cond;
        logic [UPC_W-1:0] target;
        logic             done;     // return to idle when no jump is taken
        logic             emit;     // deliver a result word on finishing
        logic             out_rd;   // result carries the read cell, zero if the index is out of range
    } ucode_t;

    // Microcode table; a jump is taken when cond holds, else done or fall through
    function automatic ucode_t ucode(input logic [UPC_W-1:0] upc);
        ucode_t u;
        u = '0;
        unique case (upc)
            U_INIT:
            begin
                u.wr = 1'b1; u.wd_sel = WD_ZERO; u.ptr_op = PTR_INC;
                u.cond = COND_PTR_TOP; u.target = U_INIT; u.done = 1'b1;
            end
            U_READ:
            begin
                u.done = 1'b1; u.emit = 1'b1; u.out_rd = 1'b1;
            end
            U_PUT:
            begin
                u.wr = 1'b1; u.wa_cur = 1'b1; u.wd_sel = WD_CHAR; u.cur_op = CUR_ADV;
                u.cond = COND_WRAP_LAST; u.target = U_SCR0;
                u.done = 1'b1; u.emit = 1'b1;
            end
            U_TAB:
            begin
                u.wr = 1'b1; u.wa_cur = 1'b1; u.wd_sel = WD_CHAR; u.cur_op = CUR_ADV;
                u.tab_dec = 1'b1; u.cond = COND_WRAP_LAST; u.target = U_SCR0;
            end
            U_TCHK:
            begin
                u.cond = COND_TAB_MORE; u.target = U_TAB; u.done = 1'b1; u.emit = 1'b1;
            end
            U_CR:
            begin
                u.cur_op = CUR_CR; u.done = 1'b1; u.emit = 1'b1;
            end
            U_LF:
            begin
                u.cur_op = CUR_LF; u.cond = COND_ROW_LAST; u.target = U_SCR0;
                u.done = 1'b1; u.emit = 1'b1;
            end
            U_RIGHT:
            begin
                u.cur_op = CUR_RIGHT; u.done = 1'b1; u.emit = 1'b1;
            end
            U_LEFT:
            begin
                u.cur_op = CUR_LEFT; u.done = 1'b1; u.emit = 1'b1;
            end
            U_UP:
            begin
                u.cur_op = CUR_UP; u.done = 1'b1; u.emit = 1'b1;
            end
            U_DOWN:
            begin
                u.cur_op = CUR_DOWN; u.done = 1'b1; u.emit = 1'b1;
            end
            U_HOME:
            begin
                u.cur_op = CUR_HOME; u.done = 1'b1; u.emit = 1'b1;
            end
            U_CLR0:
            begin
                u.cur_op = CUR_ZERO; u.ptr_op = PTR_ZERO;
            end
            U_CLR1:
            begin
                u.wr = 1'b1; u.wd_sel = WD_BLANK; u.ptr_op = PTR_INC;
                u.cond = COND_PTR_TOP; u.target = U_CLR1; u.done = 1'b1; u.emit = 1'b1;
            end
            U_BS0:
            begin
                u.cond = COND_COL_NZ; u.target = U_BS1; u.done = 1'b1; u.emit = 1'b1;
            end
            U_BS1:
            begin
                u.cur_op = CUR_BACK; u.ptr_op = PTR_CUR;
                u.cond = COND_ALWAYS; u.target = U_DEL1;
            end
            U_DEL0:
            begin
                u.ptr_op = PTR_CUR;
            end
            U_DEL1:
            begin
                u.rd = 1'b1; u.cond = COND_PTR_ROWEND; u.target = U_DEL3;
            end
            U_DEL2:
            begin
                u.wr = 1'b1; u.wd_sel = WD_RDATA; u.ptr_op = PTR_INC;
                u.cond = COND_ALWAYS; u.target = U_DEL1;
            end
            U_DEL3:
            begin
                u.wr = 1'b1; u.wd_sel = WD_BLANK; u.done = 1'b1; u.emit = 1'b1;
            end
            U_SCR0:
            begin
                u.ptr_op = PTR_ZERO;
            end
            U_SCR1:
            begin
                u.rd = 1'b1; u.ra_cols = 1'b1;
            end
            U_SCR2:
            begin
                u.wr = 1'b1; u.wd_sel = WD_RDATA; u.ptr_op = PTR_INC;
                u.cond = COND_PTR_SCR; u.target = U_SCR1;
            end
            U_SCR3:
            begin
                u.wr = 1'b1; u.wd_sel = WD_BLANK; u.ptr_op = PTR_INC;
                u.cond = COND_PTR_TOP; u.target = U_SCR3;
            end
            U_SCR4:
            begin
                u.cond = COND_TAB_MORE; u.target = U_TAB; u.done = 1'b1; u.emit = 1'b1;
            end
            default: u = '0;
        endcase
        return u;
    endfunction

endpackage

/* rtl/tcce_if.sv */
// Handshake channels of the text console engine: input word and result word.
// Depends on tcce_pkg.
interface tcce_in_if import tcce_pkg::*; ();
    logic              valid;
    logic              ready;
    logic              cmd;
    logic [CH_W-1:0]   ch;
    logic [IDX_W-1:0]  read_index;

    modport source (output valid, cmd, ch, read_index, input ready);
    modport sink (input valid, cmd, ch, read_index, output ready);
endinterface

interface tcce_out_if import tcce_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [OROW_W-1:0] cursor_row;
    logic [OCOL_W-1:0] cursor_col;
    logic [DATA_W-1:0] cursor_addr;
    logic [DATA_W-1:0] read_data;

    modport source (output valid, cursor_row, cursor_col, cursor_addr, read_data,
                    input ready);
    modport sink (input valid, cursor_row, cursor_col, cursor_addr, read_data,
                  output ready);
endinterface

/* rtl/text_console_char_engine_top.sv */
// Text console engine: microcoded sequencer over a 2048 x 32 screen memory.
// Delete and backspace shift the cells right of the cursor in its row one place
// left and blank the row's last cell; clear blanks every cell; a scroll copies
// each row up by one and blanks the bottom row.
// One word in flight at a time: a word is taken only in idle with the result slot free.
// Reset: cursor and registers go to zero, then a pass writes zero to every cell.
module text_console_char_engine_top
    import tcce_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    tcce_in_if.sink              item,
    tcce_out_if.source           result,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_idx,
    input  logic [DATA_W-1:0]    cfg_wdata
);

    logic [DATA_W-1:0]    attr_reg, base_reg;
    logic [UPC_W-1:0]     upc_reg, upc_next;
    logic [CELL_AW-1:0]   ptr_reg, ptr_next;
    logic [ROW_W-1:0]     row_reg, row_next;
    logic [COL_W-1:0]     col_reg, col_next;
    logic [TAB_CNT_W-1:0] tab_reg, tab_next;
    logic [CH_W-1:0]      ch_reg;
    logic                 in_range_reg;
    logic                 ovalid_reg, ovalid_next;
    logic [OROW_W-1:0]    orow_reg;
    logic [OCOL_W-1:0]    ocol_reg;
    logic [DATA_W-1:0]    oaddr_reg, odata_reg;

    logic [DATA_W-1:0]    screen_mem [CELLS];
    logic [DATA_W-1:0]    mem_rdata_reg;
    logic                 mem_re, mem_we;
    logic [CELL_AW-1:0]   mem_raddr, mem_waddr;
    logic [DATA_W-1:0]    mem_wdata;

    ucode_t               ucw;
    logic                 accept, cond_true, finish;
    logic                 row_last, col_last;
    logic [UPC_W-1:0]     dispatch;
    logic [DATA_W-1:0]    blank_word;

    assign accept     = item.valid && item.ready;
    assign item.ready = (upc_reg == U_IDLE) && (!ovalid_reg || result.ready);
    assign ucw        = ucode(upc_reg);
    assign row_last   = row_reg == ROW_W'(ROWS - 1);
    assign col_last   = col_reg == COL_W'(COLS - 1);
    assign blank_word = attr_reg | DATA_W'(CH_BLANK);

    // Entry point of the program for the incoming word
    always_comb
    begin
        if (item.cmd == CMD_READ)
        begin
            dispatch = U_READ;
        end
        else
        begin
            unique case (item.ch)
                CH_CR:    dispatch = U_CR;
                CH_LF:    dispatch = U_LF;
                CH_TAB:   dispatch = U_TAB;
                CH_RIGHT: dispatch = U_RIGHT;
                CH_UP:    dispatch = U_UP;
                CH_LEFT:  dispatch = U_LEFT;
                CH_DOWN:  dispatch = U_DOWN;
                CH_HOME:  dispatch = U_HOME;
                CH_DEL:   dispatch = U_DEL0;
                CH_BS:    dispatch = U_BS0;
                CH_CLR:   dispatch = U_CLR0;
                default:  dispatch = U_PUT;
            endcase
        end
    end

    always_comb
    begin
        case (ucw.cond)
            COND_ALWAYS:     cond_true = 1'b1;
            COND_WRAP_LAST:  cond_true = col_last && row_last;
            COND_ROW_LAST:   cond_true = row_last;
            COND_TAB_MORE:   cond_true = tab_reg != '0;
            COND_PTR_SCR:    cond_true = ptr_reg != CELL_AW'(CELLS - COLS - 1);
            COND_PTR_TOP:    cond_true = ptr_reg != CELL_AW'(CELLS - 1);
            COND_COL_NZ:     cond_true = col_reg != '0;
            COND_PTR_ROWEND: cond_true = ptr_reg[COL_W-1:0] == COL_W'(COLS - 1);
            default:         cond_true = 1'b0;
        endcase
    end

    assign finish = (upc_reg != U_IDLE) && !cond_true && ucw.done;

    always_comb
    begin
        if (upc_reg == U_IDLE)
            upc_next = accept ? dispatch : U_IDLE;
        else if (cond_true)
            upc_next = ucw.target;
        else if (ucw.done)
            upc_next = U_IDLE;
        else
            upc_next = upc_reg + UPC_W'(1);
    end

    // Cursor update
    always_comb
    begin
        row_next = row_reg;
        col_next = col_reg;
        unique case (ucw.cur_op)
            CUR_HOLD: ;
            CUR_ADV:
            begin
                col_next = col_reg + COL_W'(1);
                if (col_last && !row_last)
                    row_next = row_reg + ROW_W'(1);
            end
            CUR_CR:    col_next = '0;
            CUR_LF:    if (!row_last) row_next = row_reg + ROW_W'(1);
            CUR_RIGHT: if (!col_last) col_next = col_reg + COL_W'(1);
            CUR_LEFT:  if (col_reg != '0) col_next = col_reg - COL_W'(1);
            CUR_UP:    if (row_reg != '0) row_next = row_reg - ROW_W'(1);
            CUR_DOWN:  if (!row_last) row_next = row_reg + ROW_W'(1);
            CUR_HOME:
            begin
                col_next = '0;
                if (col_reg == '0)
                    row_next = '0;
            end
            CUR_BACK:  col_next = col_reg - COL_W'(1);
            CUR_ZERO:
            begin
                row_next = '0;
                col_next = '0;
            end
            default: ;
        endcase
    end

    always_comb
    begin
        case (ucw.ptr_op)
            PTR_INC:  ptr_next = ptr_reg + CELL_AW'(1);
            PTR_ZERO: ptr_next = '0;
            PTR_CUR:  ptr_next = {row_next, col_next};
            default:  ptr_next = ptr_reg;
        endcase
    end

    always_comb
    begin
        if (accept)
            tab_next = (item.cmd == CMD_PUT && item.ch == CH_TAB) ? TAB_SPACES : '0;
        else if (ucw.tab_dec)
            tab_next = tab_reg - TAB_CNT_W'(1);
        else
            tab_next = tab_reg;
    end

    always_comb
    begin
        if (finish && ucw.emit)
            ovalid_next = 1'b1;
        else if (result.ready)
            ovalid_next = 1'b0;
        else
            ovalid_next = ovalid_reg;
    end

    // Memory ports
    assign mem_re    = (accept && item.cmd == CMD_READ) || ucw.rd;
    assign mem_raddr = (upc_reg == U_IDLE) ? CELL_AW'(item.read_index)
                     : ucw.ra_cols ? ptr_reg + CELL_AW'(COLS) : ptr_reg + CELL_AW'(1);
    assign mem_we    = ucw.wr;
    assign mem_waddr = ucw.wa_cur ? {row_reg, col_reg} : ptr_reg;

    always_comb
    begin
        case (ucw.wd_sel)
            WD_CHAR:  mem_wdata = attr_reg | DATA_W'(ch_reg);
            WD_BLANK: mem_wdata = blank_word;
            WD_RDATA: mem_wdata = mem_rdata_reg;
            default:  mem_wdata = '0;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
            screen_mem[mem_waddr] <= mem_wdata;
        if (mem_re)
            mem_rdata_reg <= screen_mem[mem_raddr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            attr_reg   <= '0;
            base_reg   <= '0;
            upc_reg    <= U_INIT;
            ptr_reg    <= '0;
            row_reg    <= '0;
            col_reg    <= '0;
            tab_reg    <= '0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_idx)
                    REG_ATTRIBUTE:   attr_reg <= cfg_wdata;
                    REG_CURSOR_BASE: base_reg <= cfg_wdata;
                    default: ;
                endcase
            end
            upc_reg    <= upc_next;
            ptr_reg    <= ptr_next;
            row_reg    <= row_next;
            col_reg    <= col_next;
            tab_reg    <= tab_next;
            ovalid_reg <= ovalid_next;
        end
    end

    // Word capture and result word
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            ch_reg       <= (item.ch == CH_TAB) ? CH_BLANK : item.ch;
            in_range_reg <= 32'(item.read_index) < 32'(CELLS);
        end
        if (finish && ucw.emit)
        begin
            orow_reg  <= OROW_W'(row_next);
            ocol_reg  <= OCOL_W'(col_next);
            oaddr_reg <= base_reg + DATA_W'({row_next, col_next});
            odata_reg <= (ucw.out_rd && in_range_reg) ? mem_rdata_reg : '0;
        end
    end

    assign result.valid       = ovalid_reg;
    assign result.cursor_row  = orow_reg;
    assign result.cursor_col  = ocol_reg;
    assign result.cursor_addr = oaddr_reg;
    assign result.read_data   = odata_reg;

`ifndef ASSERT_OFF
    a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
        item.ready |-> upc_reg == U_IDLE)
        else $error("ready outside idle");
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> !item.ready)
        else $error("second word taken while busy");
    a_emit_slot_free: assert property (@(posedge clk) disable iff (!rst_n)
        (finish && ucw.emit) |-> !ovalid_reg)
        else $error("result overwrites pending word");
    a_tab_busy: assert property (@(posedge clk) disable iff (!rst_n)
        tab_reg != '0 |-> upc_reg != U_IDLE)
        else $error("tab spaces left over in idle");
`endif

endmodule
